### rtl/rbsi_pkg.sv
// Package for the ray/box slab intersection core.
// Holds default widths and the configuration register indexes; no dependencies.
package rbsi_pkg;

  localparam int unsigned CoordWidthDefault = 32;
  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned NumCfgRegs        = 6;
  localparam int unsigned CfgIdxWidth       = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

endpackage

### rtl/rbsi_div.sv
// Pipelined restoring divider for one slab bound: saturated fixed-point quotient.
// One quotient bit per stage; uses rbsi_pkg for defaults only.
module rbsi_div import rbsi_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDefault,
  parameter int unsigned FracBits   = FracBitsDefault,
  // Width of the magnitude of the shifted numerator.
  localparam int unsigned NumW = CoordWidth + 1 + FracBits,
  localparam int unsigned QW   = CoordWidth
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  // Numerator difference (bound - origin), CoordWidth+1 bits signed.
  input  logic signed [CoordWidth:0] num_i,
  input  logic signed [CoordWidth-1:0] den_i,
  // Saturated quotient of the last stage; stages advance only while en_i is high.
  output logic signed [QW-1:0]  quo_o
);

  // Per-stage registers: partial remainder, remaining dividend bits, quotient bits.
  logic [NumW-1:0]       dvd_q [NumW+1];
  logic [CoordWidth:0]   rem_q [NumW+1];
  logic [NumW-1:0]       quo_q [NumW+1];
  logic [CoordWidth-1:0] den_q [NumW+1];
  logic                  neg_q [NumW+1];

  logic [CoordWidth:0]   num_mag;
  logic [CoordWidth-1:0] den_mag;

  // Magnitudes at the pipeline input.
  always_comb begin
    num_mag = num_i[CoordWidth] ? (~num_i + 1'b1) : num_i;
    den_mag = den_i[CoordWidth-1] ? (~den_i + 1'b1) : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q[0] <= {num_mag, {FracBits{1'b0}}};
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      den_q[0] <= den_mag;
      neg_q[0] <= num_i[CoordWidth] ^ den_i[CoordWidth-1];
    end
  end

  // One quotient bit per stage.
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [CoordWidth+1:0] trial;
    logic [CoordWidth+1:0] shifted;
    always_comb begin
      shifted = {rem_q[s], dvd_q[s][NumW-1]};
      trial   = shifted - {2'b00, den_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[s+1] <= {dvd_q[s][NumW-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (!trial[CoordWidth+1]) begin
          rem_q[s+1] <= trial[CoordWidth:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted[CoordWidth:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // Sign and saturation on the final magnitude.
  localparam logic [NumW-1:0] MagMax = NumW'({1'b0, {(QW-1){1'b1}}});
  logic [NumW-1:0] mag;
  always_comb begin
    mag = quo_q[NumW];
    if (neg_q[NumW]) begin
      if (mag > MagMax) begin
        quo_o = {1'b1, {(QW-1){1'b0}}};
      end else begin
        quo_o = QW'(~mag + 1'b1);
      end
    end else begin
      quo_o = (mag > MagMax) ? {1'b0, {(QW-1){1'b1}}} : QW'(mag);
    end
  end

endmodule

### rtl/rbsi_axis.sv
// One axis of the slab test: differences, two dividers and interval ordering.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_axis import rbsi_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDefault,
  parameter int unsigned FracBits   = FracBitsDefault,
  localparam int unsigned Lat = CoordWidth + FracBits + 2
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [CoordWidth-1:0] lo_i,
  input  logic signed [CoordWidth-1:0] hi_i,
  input  logic signed [CoordWidth-1:0] org_i,
  input  logic signed [CoordWidth-1:0] dir_i,
  // Ordered interval, from the dividers and the side information delayed to match.
  output logic signed [CoordWidth-1:0] lower_o,
  output logic signed [CoordWidth-1:0] upper_o,
  output logic                         inside_o
);

  localparam logic signed [CoordWidth-1:0] QMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] QMin = {1'b1, {(CoordWidth-1){1'b0}}};

  logic signed [CoordWidth:0] dlo, dhi;
  logic signed [CoordWidth-1:0] qlo, qhi;
  logic in_slab;

  // Exact differences and slab membership.
  always_comb begin
    dlo     = {lo_i[CoordWidth-1], lo_i} - {org_i[CoordWidth-1], org_i};
    dhi     = {hi_i[CoordWidth-1], hi_i} - {org_i[CoordWidth-1], org_i};
    in_slab = (org_i >= lo_i) && (org_i <= hi_i);
  end

  rbsi_div #(.CoordWidth(CoordWidth), .FracBits(FracBits)) u_div_lo (
    .clk_i, .en_i, .num_i(dlo), .den_i(dir_i), .quo_o(qlo));
  rbsi_div #(.CoordWidth(CoordWidth), .FracBits(FracBits)) u_div_hi (
    .clk_i, .en_i, .num_i(dhi), .den_i(dir_i), .quo_o(qhi));

  // Side information delayed to match the divider.
  logic [1:0] side_q [Lat];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= {dir_i == '0 ? 1'b1 : 1'b0, in_slab};
      for (int i = 1; i < Lat; i++) side_q[i] <= side_q[i-1];
    end
  end
  logic sign_q [Lat];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q[0] <= dir_i[CoordWidth-1];
      for (int i = 1; i < Lat; i++) sign_q[i] <= sign_q[i-1];
    end
  end

  // Order by direction sign, or pick the unbounded/empty interval for a zero direction.
  logic [1:0] side;
  always_comb begin
    side     = side_q[Lat-1];
    inside_o = side[0];
    if (side[1]) begin
      lower_o = side[0] ? QMin : QMax;
      upper_o = side[0] ? QMax : QMin;
    end else if (sign_q[Lat-1]) begin
      lower_o = qhi;
      upper_o = qlo;
    end else begin
      lower_o = qlo;
      upper_o = qhi;
    end
  end

endmodule

### rtl/ray_box_slab_intersect_core.sv
// Ray/box slab intersection core: three axis pipelines and a final combine stage.
// Datapath: dividers with one quotient bit per stage, then a registered combine stage.
// Throughput: one item per cycle; the whole pipeline advances unless the output stalls.
// Reset: asynchronous active low; clears valid bits and loads the unit box [0, 1.0].
// Depends on rbsi_pkg and rbsi_axis.
module ray_box_slab_intersect_core import rbsi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault,
  parameter int unsigned FRAC_BITS   = FracBitsDefault,
  localparam int unsigned DataBytes  = (6 * COORD_WIDTH + 7) / 8,
  localparam int unsigned OutBits    = 2 * COORD_WIDTH + 3,
  localparam int unsigned OutBytes   = (OutBits + 7) / 8,
  localparam int unsigned Lat        = COORD_WIDTH + FRAC_BITS + 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]     cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
  input  logic [8*DataBytes-1:0]     s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // line_hit, segment_hit, entry_param, exit_param, origin_inside from bit 0 up
  output logic [8*OutBytes-1:0]      m_axis_tdata
);

  localparam int unsigned W = COORD_WIDTH;
  localparam logic signed [W-1:0] QOne = W'(64'(1) << FRAC_BITS);
  localparam logic signed [W-1:0] QMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMin = {1'b1, {(W-1){1'b0}}};

  // Box bound registers.
  logic signed [W-1:0] bnd_q [NumCfgRegs];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfgRegs; i++) bnd_q[i] <= i[0] ? QOne : '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_X: bnd_q[0] <= cfg_data_i;
        REG_MAX_X: bnd_q[1] <= cfg_data_i;
        REG_MIN_Y: bnd_q[2] <= cfg_data_i;
        REG_MAX_Y: bnd_q[3] <= cfg_data_i;
        REG_MIN_Z: bnd_q[4] <= cfg_data_i;
        REG_MAX_Z: bnd_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global stall: the pipeline moves when the output register can take data.
  logic en;
  logic out_vld_q;
  logic [Lat-1:0] vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Three axis pipelines.
  logic signed [W-1:0] lower [3];
  logic signed [W-1:0] upper [3];
  logic                in_box [3];
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_axis #(.CoordWidth(W), .FracBits(FRAC_BITS)) u_axis (
      .clk_i,
      .en_i    (en),
      .lo_i    (bnd_q[2*a]),
      .hi_i    (bnd_q[2*a+1]),
      .org_i   (s_axis_tdata[a*W +: W]),
      .dir_i   (s_axis_tdata[(a+3)*W +: W]),
      .lower_o (lower[a]),
      .upper_o (upper[a]),
      .inside_o(in_box[a])
    );
  end

  // Interval intersection and flags into the output register.
  logic signed [W-1:0] ent_d, ext_d, t01, t02, u01, u02;
  always_comb begin
    t01   = (lower[0] > lower[1]) ? lower[0] : lower[1];
    ent_d = (t01 > lower[2]) ? t01 : lower[2];
    u01   = (upper[0] < upper[1]) ? upper[0] : upper[1];
    ext_d = (u01 < upper[2]) ? u01 : upper[2];
    t02   = ent_d;
    u02   = ext_d;
  end

  logic signed [W-1:0] ent_q, ext_q;
  logic hit_q, seg_q, ins_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= t02;
      ext_q <= u02;
      hit_q <= t02 <= u02;
      seg_q <= (t02 <= u02) && (t02 <= QOne) && (u02 >= 0);
      ins_q <= in_box[0] && in_box[1] && in_box[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[Lat-1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = (8*OutBytes)'({ins_q, ext_q, ent_q, seg_q, hit_q});

  // Output holds while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed during stall");
  // Segment hit implies line hit.
  a_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("segment hit without line hit");
  // Input ready follows the output register.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

### verif/tb_ray_box_slab_intersect_core.sv
// Testbench for the ray/box slab intersection core: directed and random lines
// against several boxes, with a predictor here. Depends on rbsi_pkg and the core.
module tb_ray_box_slab_intersect_core;
  import rbsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int Lat = CW + FB + 2;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd65536;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic             in_box;
    logic [CW-1:0]    exit_p;
    logic [CW-1:0]    entry_p;
    logic             seg;
    logic             hit;
  } hit_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // line_hit, segment_hit, entry_param, exit_param, origin_inside from bit 0 up
  logic [71:0] m_axis_tdata;

  ray_box_slab_intersect_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: box bounds, indexed by register.
  logic signed [CW-1:0] box_bound [NumCfgRegs];
  hit_rec_t hits_due [$];
  int err_count = 0;
  int hit_count = 0;
  int seg_count = 0;
  int result_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  // Fixed-point quotient, truncated toward zero and clamped.
  function automatic longint slab_div(longint num, longint den);
    longint q;
    q = (num * QONE) / den;
    if (q > QMAX) return QMAX;
    if (q < QMIN) return QMIN;
    return q;
  endfunction

  function automatic hit_rec_t predict_hit(logic [191:0] ray);
    longint entry, ex, lo, hi, o, d, lower, upper;
    bit in_box;
    hit_rec_t r;
    entry = QMIN;
    ex = QMAX;
    in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo = box_bound[2*a];
      hi = box_bound[2*a+1];
      o = $signed(ray[a*CW +: CW]);
      d = $signed(ray[(a+3)*CW +: CW]);
      if (d > 0) begin
        lower = slab_div(lo - o, d);
        upper = slab_div(hi - o, d);
      end else if (d < 0) begin
        lower = slab_div(hi - o, d);
        upper = slab_div(lo - o, d);
      end else if (o >= lo && o <= hi) begin
        lower = QMIN;
        upper = QMAX;
      end else begin
        lower = QMAX;
        upper = QMIN;
      end
      if (lower > entry) entry = lower;
      if (upper < ex) ex = upper;
      if (!(o >= lo && o <= hi)) in_box = 1'b0;
    end
    r.hit = entry <= ex;
    r.seg = r.hit && entry <= QONE && ex >= 0;
    r.entry_p = entry[CW-1:0];
    r.exit_p = ex[CW-1:0];
    r.in_box = in_box;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Receiver: random or held-off tready.
  always @(posedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    hit_rec_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[66:0];
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = hits_due.pop_front();
        result_count++;
        hit_count += want.hit;
        seg_count += want.seg;
        if (got.hit !== want.hit) report_mismatch("line_hit", got.hit, want.hit);
        if (got.seg !== want.seg) report_mismatch("segment_hit", got.seg, want.seg);
        if (got.entry_p !== want.entry_p)
          report_mismatch("entry_param", $signed(got.entry_p), $signed(want.entry_p));
        if (got.exit_p !== want.exit_p)
          report_mismatch("exit_param", $signed(got.exit_p), $signed(want.exit_p));
        if (got.in_box !== want.in_box)
          report_mismatch("origin_inside", got.in_box, want.in_box);
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Watchdog expired with %0d results outstanding", hits_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one item; tvalid stays high afterwards so items can follow back to back.
  task automatic send_ray(logic [191:0] ray);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tdata <= ray;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    hits_due.push_back(predict_hit(ray));
  endtask

  task automatic drain_results();
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (Lat + 4) @(posedge clk_i);
  endtask

  task automatic write_box(logic signed [CW-1:0] b [NumCfgRegs]);
    for (int i = 0; i < NumCfgRegs; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= b[i];
      box_bound[i] = b[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [191:0] make_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    return {dz, dy, dx, oz, oy, ox};
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262144)) - 131072);
      2: return 32'h8000_0000 + $urandom_range(3);
      3: return 32'h7FFF_FFFF - $urandom_range(3);
      4: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 4)) - 2) * 32'sd65536;
    endcase
  endfunction

  // Directed lines against the unit box after reset.
  task automatic test_directed();
    send_ray(make_ray(32'hFFFF_0000, 32'h8000, 32'h8000, 32'h0001_0000, 0, 0));
    send_ray(make_ray(32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
    send_ray(make_ray(32'h0002_0000, 32'h8000, 32'h8000, 0, 32'h0001_0000, 0));
    send_ray(make_ray(32'h8000, 32'h0003_0000, 32'h8000, 0, 32'hFFFF_0000, 0));
    send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1));
    send_ray(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_ray(make_ray(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(make_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                      32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
    send_ray(make_ray(32'h8000, 32'h8000, 32'h8000, 32'h0000_4000, 0, 0));
    send_ray(make_ray(32'hFFF0_0000, 32'h8000, 32'h8000, 32'h0001_0000, 0, 0));
    send_ray(make_ray(32'h0010_0000, 32'h8000, 32'h8000, 32'h0001_0000, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 0, 0, 0));
    s_axis_tvalid <= 1'b0;
    drain_results();
  endtask

  // Random lines with full-range and near-box values.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_ray(make_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord()));
    s_axis_tvalid <= 1'b0;
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering lines.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        for (int i = 0; i < 120; i++)
          send_ray(make_ray(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()));
        s_axis_tvalid <= 1'b0;
      end
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join
    drain_results();
  endtask

  task automatic test_box_settings();
    logic signed [CW-1:0] b [NumCfgRegs];
    // Extreme box covering the full range.
    b = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF};
    write_box(b);
    test_random(60);
    // Inverted box on one axis.
    b = '{32'sh0002_0000, 32'shFFFE_0000, -32'sd65536, 32'sd65536,
          0, 32'sd1};
    write_box(b);
    test_random(40);
    // Degenerate point box.
    b = '{0, 0, 0, 0, 0, 0};
    write_box(b);
    test_random(40);
    // Random small boxes.
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < NumCfgRegs; i += 2) begin
        b[i] = rand_coord();
        b[i+1] = b[i] + $urandom_range(0, 200000);
      end
      write_box(b);
      test_random(40);
    end
  endtask

  initial begin
    for (int i = 0; i < NumCfgRegs; i++) box_bound[i] = (i % 2) ? 32'(QONE) : 32'sd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 27;
    recv_idle_pct = 63;
    test_directed();
    test_random(80);
    send_idle_pct = 63;
    recv_idle_pct = 27;
    test_box_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(60);
    $display("Checked %0d results: %0d line hits, %0d segment hits, over seven boxes.",
             result_count, hit_count, seg_count);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
